/* src/bitmap_page_allocator_refcount_top_macros.svh */
// Assertion macros for the page allocator.
`ifndef BITMAP_PAGE_ALLOCATOR_REFCOUNT_TOP_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_REFCOUNT_TOP_MACROS_SVH
`ifndef SYNTH
`define BPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same cycle implication");
`define BPA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle implication");
`else
`define BPA_ASSERT_IMP(lbl, ante, cons)
`define BPA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* src/bpa_pkg.sv */
`default_nettype none
package bpa_pkg;
  localparam int NUM_PAGES = 65536;
  localparam int WORD_BITS = 64;
  localparam int NUM_WORDS = NUM_PAGES / WORD_BITS;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WADDR_W   = $clog2(NUM_WORDS);
  localparam int CNT_W     = PAGE_W + 1;

  typedef logic [PAGE_W-1:0]    page_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [WORD_BITS-1:0] word_t;

  localparam logic [2:0] OP_ALLOC_ONE = 3'd0;
  localparam logic [2:0] OP_ALLOC_RUN = 3'd1;
  localparam logic [2:0] OP_FREE      = 3'd2;
  localparam logic [2:0] OP_REF       = 3'd3;
  localparam logic [2:0] OP_UNREF     = 3'd4;
  localparam logic [2:0] OP_MARK_FREE = 3'd5;
  localparam logic [2:0] OP_MARK_USED = 3'd6;
  localparam logic [2:0] OP_QUERY     = 3'd7;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam logic [7:0] RC_MAX = 8'd255;

  // Position of the lowest clear bit of a bitmap word.
  function automatic logic [BIT_W-1:0] low_free(word_t w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (!w[k]) r = BIT_W'(k);
    end
    return r;
  endfunction
endpackage
`default_nettype wire

/* src/bitmap_page_allocator_refcount_top.sv */
// Page allocator: used bitmap (1024 x 64) and reference counts (65536 x 8) in RAM.
// Flow: free, ref, unref, query read the page's bitmap word and count, then show the result;
// single-page allocation scans bitmap words in turn from the hint, wrapping once; run search
// checks a page a cycle, pausing at each word read; the run and range marking go page by page.
// Throughput: one item at a time, the next taken in the cycle a result shows; no result stall.
// Reset: a clearing pass over every page (busy high) fills the bitmap and zeroes counts.
`default_nettype none
`include "bitmap_page_allocator_refcount_top_macros.svh"
module bitmap_page_allocator_refcount_top
  import bpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        opcode,
  input  wire logic [PAGE_W-1:0] page_index,
  input  wire logic [CNT_W-1:0]  page_count,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CNT_W-1:0]  cfg_data,
  output logic                   done,
  output logic [1:0]             status,
  output logic [PAGE_W-1:0]      result_page,
  output logic [7:0]             ref_count,
  output logic [CNT_W-1:0]       free_pages
);

  // Controller states.
  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_EXEC    = 4'd2;
  localparam logic [3:0] S_SCAN    = 4'd3;
  localparam logic [3:0] S_CHK     = 4'd4;
  localparam logic [3:0] S_RUN_RD  = 4'd5;
  localparam logic [3:0] S_RUN_BIT = 4'd6;
  localparam logic [3:0] S_RNG_RD  = 4'd7;
  localparam logic [3:0] S_RNG_MOD = 4'd8;

  // Range engine modes: clear bits, set bits, or take pages for a run.
  localparam logic [1:0] M_FREE = 2'd0;
  localparam logic [1:0] M_USED = 2'd1;
  localparam logic [1:0] M_TAKE = 2'd2;

  localparam logic [WADDR_W:0] WORDS_FULL = (WADDR_W + 1)'(NUM_WORDS);

  // The two state memories. Read data is registered and held between reads.
  word_t      bm_mem [NUM_WORDS];
  logic [7:0] rc_mem [NUM_PAGES];

  logic               bm_re, bm_we, rc_re, rc_we;
  logic [WADDR_W-1:0] bm_raddr, bm_waddr;
  word_t              bm_wdata, bm_rdata;
  page_t              rc_raddr, rc_waddr;
  logic [7:0]         rc_wdata, rc_rdata;

  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    if (bm_re) bm_rdata <= bm_mem[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (rc_we) rc_mem[rc_waddr] <= rc_wdata;
    if (rc_re) rc_rdata <= rc_mem[rc_raddr];
  end

  // Control and working registers.
  logic [3:0]         state, state_next;
  page_t              clr, clr_next;
  logic [2:0]         op, op_next;
  page_t              pi, pi_next;
  cnt_t               cnt, cnt_next;
  logic [WADDR_W:0]   w, w_next, limit, limit_next;
  logic               pass, pass_next;
  cnt_t               p, p_next, i, i_next, len, len_next;
  page_t              start_pg, start_pg_next;
  logic [1:0]         mode, mode_next;
  logic [7:0]         rc_hold, rc_hold_next;
  cnt_t               hint, hint_next, fc, fc_next, total_pages;
  logic               done_next;
  logic [1:0]         status_next;
  page_t              result_page_next;
  logic [7:0]         ref_count_next;

  // Tracked pages, clamped to the memory size, and the word bounds of a scan.
  cnt_t               tot;
  cnt_t               tot_round;
  logic [WADDR_W:0]   end_word, start_word;
  logic               pi_valid, page_used, scan_hit;
  logic [BIT_W-1:0]   scan_bit;
  page_t              scan_idx, run_start;
  word_t              bit_mask;
  logic [7:0]         rc_inc;

  assign tot        = (total_pages > CNT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES) : total_pages;
  assign tot_round  = tot + CNT_W'(WORD_BITS - 1);
  assign end_word   = tot_round[CNT_W-1:BIT_W];
  assign start_word = (hint[CNT_W-1:BIT_W] > WORDS_FULL) ? WORDS_FULL : hint[CNT_W-1:BIT_W];
  assign pi_valid   = (pi != '0) && ({1'b0, pi} < tot);
  assign page_used  = bm_rdata[pi[BIT_W-1:0]];
  assign scan_hit   = (~bm_rdata) != '0;
  assign scan_bit   = low_free(bm_rdata);
  assign scan_idx   = {w[WADDR_W-1:0], scan_bit};
  assign run_start  = (len == '0) ? p[PAGE_W-1:0] : start_pg;
  assign bit_mask   = word_t'(1) << p[BIT_W-1:0];
  assign rc_inc     = (rc_rdata == '0) ? 8'd2 : ((rc_rdata < RC_MAX) ? rc_rdata + 8'd1 : rc_rdata);

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign free_pages = fc;

  always_comb begin
    state_next       = state;
    clr_next         = clr;
    op_next          = op;
    pi_next          = pi;
    cnt_next         = cnt;
    w_next           = w;
    limit_next       = limit;
    pass_next        = pass;
    p_next           = p;
    i_next           = i;
    len_next         = len;
    start_pg_next    = start_pg;
    mode_next        = mode;
    rc_hold_next     = rc_hold;
    hint_next        = hint;
    fc_next          = fc;
    done_next        = 1'b0;
    status_next      = status;
    result_page_next = result_page;
    ref_count_next   = ref_count;
    bm_re = 1'b0; bm_raddr = '0; bm_we = 1'b0; bm_waddr = '0; bm_wdata = '0;
    rc_re = 1'b0; rc_raddr = '0; rc_we = 1'b0; rc_waddr = '0; rc_wdata = '0;

    case (state)
      S_CLR: begin
        rc_we = 1'b1;
        rc_waddr = clr;
        if (clr < PAGE_W'(NUM_WORDS)) begin
          bm_we = 1'b1;
          bm_waddr = clr[WADDR_W-1:0];
          bm_wdata = '1;
        end
        if (clr == '1) state_next = S_IDLE;
        else clr_next = clr + 1'b1;
      end

      S_IDLE: begin
        if (start) begin
          op_next  = opcode;
          pi_next  = page_index;
          cnt_next = page_count;
          if (opcode == OP_ALLOC_ONE ||
              (opcode == OP_ALLOC_RUN && page_count == CNT_W'(1))) begin
            w_next     = start_word;
            limit_next = end_word;
            pass_next  = 1'b0;
            state_next = S_SCAN;
          end else if (opcode == OP_ALLOC_RUN) begin
            if (page_count == '0) begin
              done_next = 1'b1;
              status_next = ST_NOMEM;
              result_page_next = '0;
              ref_count_next = '0;
            end else begin
              p_next = '0;
              len_next = '0;
              state_next = S_RUN_RD;
            end
          end else begin
            // Fetch the addressed page's bitmap word and count.
            bm_re = 1'b1;
            bm_raddr = page_index[PAGE_W-1:BIT_W];
            rc_re = 1'b1;
            rc_raddr = page_index;
            state_next = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        done_next = 1'b1;
        state_next = S_IDLE;
        result_page_next = pi;
        status_next = ST_DONE;
        ref_count_next = '0;
        case (op)
          OP_FREE, OP_UNREF: begin
            if (!pi_valid || (op == OP_FREE && !page_used)) begin
              status_next = ST_IGNORED;
            end else begin
              rc_we = 1'b1;
              rc_waddr = pi;
              if (rc_rdata > 8'd1) begin
                rc_wdata = rc_rdata - 8'd1;
                ref_count_next = rc_rdata - 8'd1;
              end else begin
                rc_wdata = '0;
                if (page_used) begin
                  bm_we = 1'b1;
                  bm_waddr = pi[PAGE_W-1:BIT_W];
                  bm_wdata = bm_rdata & ~(word_t'(1) << pi[BIT_W-1:0]);
                  fc_next = fc + 1'b1;
                  if ({1'b0, pi} < hint) hint_next = {1'b0, pi};
                end
              end
            end
          end
          OP_REF: begin
            if (!pi_valid) begin
              status_next = ST_IGNORED;
            end else begin
              rc_we = 1'b1;
              rc_waddr = pi;
              rc_wdata = rc_inc;
              ref_count_next = rc_inc;
            end
          end
          OP_MARK_FREE, OP_MARK_USED: begin
            done_next = 1'b0;
            rc_hold_next = rc_rdata;
            p_next = {1'b0, pi};
            i_next = '0;
            mode_next = (op == OP_MARK_USED) ? M_USED : M_FREE;
            state_next = S_RNG_RD;
          end
          default: begin
            if (!pi_valid) begin
              status_next = ST_IGNORED;
            end else begin
              status_next = page_used ? ST_DONE : ST_IGNORED;
              ref_count_next = rc_rdata;
            end
          end
        endcase
      end

      // Next-fit word scan: from the hint word to the end, then wrap once.
      S_SCAN: begin
        if (w < limit) begin
          bm_re = 1'b1;
          bm_raddr = w[WADDR_W-1:0];
          state_next = S_CHK;
        end else if (!pass) begin
          pass_next = 1'b1;
          w_next = '0;
          limit_next = start_word;
        end else begin
          done_next = 1'b1;
          status_next = ST_NOMEM;
          result_page_next = '0;
          ref_count_next = '0;
          state_next = S_IDLE;
        end
      end

      S_CHK: begin
        if (scan_hit) begin
          done_next = 1'b1;
          state_next = S_IDLE;
          if ({1'b0, scan_idx} >= tot) begin
            status_next = ST_NOMEM;
            result_page_next = '0;
            ref_count_next = '0;
          end else begin
            bm_we = 1'b1;
            bm_waddr = w[WADDR_W-1:0];
            bm_wdata = bm_rdata | (word_t'(1) << scan_bit);
            rc_we = 1'b1;
            rc_waddr = scan_idx;
            rc_wdata = 8'd1;
            if (fc != '0) fc_next = fc - 1'b1;
            hint_next = {1'b0, scan_idx} + 1'b1;
            status_next = ST_DONE;
            result_page_next = scan_idx;
            ref_count_next = 8'd1;
          end
        end else begin
          w_next = w + 1'b1;
          state_next = S_SCAN;
        end
      end

      // First-fit run search, one page a cycle, one word read per 64 pages.
      S_RUN_RD, S_RUN_BIT: begin
        if (p >= tot) begin
          done_next = 1'b1;
          status_next = ST_NOMEM;
          result_page_next = '0;
          ref_count_next = '0;
          state_next = S_IDLE;
        end else if (state == S_RUN_RD) begin
          bm_re = 1'b1;
          bm_raddr = p[PAGE_W-1:BIT_W];
          state_next = S_RUN_BIT;
        end else begin
          p_next = p + 1'b1;
          if (p_next[BIT_W-1:0] == '0) state_next = S_RUN_RD;
          if (bm_rdata[p[BIT_W-1:0]]) begin
            len_next = '0;
          end else begin
            start_pg_next = run_start;
            len_next = len + 1'b1;
            if (len + 1'b1 == cnt) begin
              p_next = {1'b0, run_start};
              i_next = '0;
              mode_next = M_TAKE;
              state_next = S_RNG_RD;
            end
          end
        end
      end

      // Range engine: read-modify-write of one page's bit at a time, a read state then a modify state.
      S_RNG_RD: begin
        if (i >= cnt || p[CNT_W-1]) begin
          done_next = 1'b1;
          status_next = ST_DONE;
          state_next = S_IDLE;
          if (mode == M_TAKE) begin
            result_page_next = start_pg;
            ref_count_next = 8'd1;
          end else begin
            result_page_next = pi;
            ref_count_next = rc_hold;
          end
        end else begin
          bm_re = 1'b1;
          bm_raddr = p[PAGE_W-1:BIT_W];
          state_next = S_RNG_MOD;
        end
      end

      S_RNG_MOD: begin
        bm_we = 1'b1;
        bm_waddr = p[PAGE_W-1:BIT_W];
        bm_wdata = (mode == M_FREE) ? (bm_rdata & ~bit_mask) : (bm_rdata | bit_mask);
        if (mode == M_TAKE) begin
          rc_we = 1'b1;
          rc_waddr = p[PAGE_W-1:0];
          rc_wdata = 8'd1;
          if (fc != '0) fc_next = fc - 1'b1;
        end else if (mode == M_USED) begin
          if (!bm_rdata[p[BIT_W-1:0]] && fc != '0) fc_next = fc - 1'b1;
        end else begin
          if (bm_rdata[p[BIT_W-1:0]]) fc_next = fc + 1'b1;
        end
        p_next = p + 1'b1;
        i_next = i + 1'b1;
        state_next = S_RNG_RD;
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr         <= '0;
      fc          <= '0;
      hint        <= '0;
      total_pages <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      fc    <= fc_next;
      hint  <= hint_next;
      done  <= done_next;
      if (cfg_valid && cfg_ready) total_pages <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    op          <= op_next;
    pi          <= pi_next;
    cnt         <= cnt_next;
    w           <= w_next;
    limit       <= limit_next;
    pass        <= pass_next;
    p           <= p_next;
    i           <= i_next;
    len         <= len_next;
    start_pg    <= start_pg_next;
    mode        <= mode_next;
    rc_hold     <= rc_hold_next;
    status      <= status_next;
    result_page <= result_page_next;
    ref_count   <= ref_count_next;
  end

  // A result is only ever shown with the controller back at idle.
  `BPA_ASSERT_IMP(a_done_idle, done, !busy)
  // Every accepted item either finishes at once or keeps the block busy.
  `BPA_ASSERT_NXT(a_start_busy, start && !busy, busy || done)
  // The free count only moves while an item is being worked on.
  `BPA_ASSERT_NXT(a_fc_idle, !busy && !start, $stable(free_pages))

endmodule
`default_nettype wire
